// ----- hw/rtl/mac_list_response_parser_defines.svh -----
// Assertion macros for the file that checks its own logic.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MAC_LIST_RESPONSE_PARSER_DEFINES_SVH
`define MAC_LIST_RESPONSE_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold in the same cycle.
`define MLRP_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define MLRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MLRP_ASSERT(label, cond, msg)
`define MLRP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/mlrp_pkg.sv -----
package mlrp_pkg;

    // Default build values for the top-level parameters.
    localparam int MAX_DEVICES_DEF    = 5;
    localparam int ADDRESS_DIGITS_DEF = 12;

    // Width of one device address and of one hex digit.
    localparam int ADDR_W  = 48;
    localparam int DIGIT_W = 4;

    // Characters of interest in the reply.
    localparam logic [7:0] CHAR_O    = 8'h4F;
    localparam logic [7:0] CHAR_K    = 8'h4B;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_9    = 8'h39;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_F    = 8'h46;

    // Input operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_CHAR  = 1'b1;

    // Scan termination codes.
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_INVALID  = 2'd1,
        ERR_OVERFLOW = 2'd2
    } err_code_t;

    // Classification of one received character.
    typedef struct packed {
        logic               is_hex;
        logic [DIGIT_W-1:0] hex_val;
        logic               is_o;
        logic               is_k;
        logic               is_filler;
    } char_class_t;

endpackage

// ----- hw/rtl/mlrp_char_class.sv -----
module mlrp_char_class (
    input  logic [7:0]                rx_char,
    output mlrp_pkg::char_class_t     cls
);

    logic is_dec;
    logic is_alpha;

    // Range checks for the two digit groups.
    assign is_dec   = (rx_char >= mlrp_pkg::CHAR_0) && (rx_char <= mlrp_pkg::CHAR_9);
    assign is_alpha = (rx_char >= mlrp_pkg::CHAR_A) && (rx_char <= mlrp_pkg::CHAR_F);

    // Digit value and separator flags.
    always_comb
    begin
        cls.is_hex  = is_dec || is_alpha;
        cls.hex_val = '0;
        if (is_dec)
        begin
            cls.hex_val = mlrp_pkg::DIGIT_W'(rx_char - mlrp_pkg::CHAR_0);
        end
        else if (is_alpha)
        begin
            cls.hex_val = mlrp_pkg::DIGIT_W'(rx_char - mlrp_pkg::CHAR_A + 8'd10);
        end
        cls.is_o      = (rx_char == mlrp_pkg::CHAR_O);
        cls.is_k      = (rx_char == mlrp_pkg::CHAR_K);
        cls.is_filler = cls.is_o || cls.is_k ||
                        (rx_char == mlrp_pkg::CHAR_CR) || (rx_char == mlrp_pkg::CHAR_LF);
    end

endmodule

// ----- hw/rtl/mac_list_response_parser.sv -----
// Device-list reply parser. Each input word is either a start command, which opens a new
// scan, or one received character. Every accepted word yields exactly one result word,
// presented in the cycle after acceptance from an output register; a new word is accepted
// in every cycle in which the output register is empty or being emptied, so the sustained
// rate is one character per clock while results are drained, one state update per word.
// Uppercase hex digits build ADDRESS_DIGITS-digit addresses, CR, LF, 'O' and 'K' are
// allowed, "OK" ends the scan, and any other character ends it with an invalid-character
// error. A digit after MAX_DEVICES complete addresses ends it with an overflow error. The
// preferred address register may be written only while the block is idle. After reset the
// block reports a finished scan until the first start command; no clearing pass is needed.
`include "mac_list_response_parser_defines.svh"

module mac_list_response_parser #(
    parameter int MAX_DEVICES    = mlrp_pkg::MAX_DEVICES_DEF,
    parameter int ADDRESS_DIGITS = mlrp_pkg::ADDRESS_DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mlrp_pkg::ADDR_W-1:0]   cfg_data,
    // Input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic [7:0]                    rx_char,
    // Result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          done_res,
    output logic [1:0]                    error_code,
    output logic [2:0]                    device_count,
    output logic                          address_complete,
    output logic [mlrp_pkg::ADDR_W-1:0]   new_address,
    output logic [2:0]                    chosen_index,
    output logic [mlrp_pkg::ADDR_W-1:0]   chosen_address
);

    localparam int ADDR_W = mlrp_pkg::ADDR_W;
    localparam int DIG_W  = $clog2(ADDRESS_DIGITS + 1);
    localparam int CNT_W  = $clog2(MAX_DEVICES + 1);

    mlrp_pkg::char_class_t cls;

    logic                 in_fire;
    logic [ADDR_W-1:0]    preferred_reg;

    // Scan state
    logic [DIG_W-1:0]     digit_offset_reg,   digit_offset_next;
    logic [ADDR_W-1:0]    address_shift_reg,  address_shift_next;
    logic [CNT_W-1:0]     found_count_reg,    found_count_next;
    logic                 prev_was_o_reg,     prev_was_o_next;
    logic                 finished_reg,       finished_next;
    logic [1:0]           finish_error_reg,   finish_error_next;
    logic                 match_seen_reg,     match_seen_next;
    logic [CNT_W-1:0]     choice_index_reg,   choice_index_next;
    logic [ADDR_W-1:0]    choice_address_reg, choice_address_next;

    // Step results
    logic                 complete;
    logic [ADDR_W-1:0]    completed;
    logic [ADDR_W-1:0]    shift_val;
    logic [DIG_W-1:0]     off_inc;

    // Output register
    logic                 out_valid_reg;
    logic                 done_reg;
    logic [1:0]           error_code_reg;
    logic [2:0]           device_count_reg;
    logic                 complete_reg;
    logic [ADDR_W-1:0]    new_address_reg;
    logic [2:0]           chosen_index_reg;
    logic [ADDR_W-1:0]    chosen_address_reg;

    mlrp_char_class u_char_class (
        .rx_char (rx_char),
        .cls     (cls)
    );

    // Handshakes: the configuration port never stalls, the input stalls only on a full
    // output register that is not being drained.
    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    // Preferred address register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preferred_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            preferred_reg <= cfg_data;
        end
    end

    // Next scan state for the accepted word.
    always_comb
    begin
        digit_offset_next   = digit_offset_reg;
        address_shift_next  = address_shift_reg;
        found_count_next    = found_count_reg;
        prev_was_o_next     = prev_was_o_reg;
        finished_next       = finished_reg;
        finish_error_next   = finish_error_reg;
        match_seen_next     = match_seen_reg;
        choice_index_next   = choice_index_reg;
        choice_address_next = choice_address_reg;
        complete            = 1'b0;
        completed           = '0;
        shift_val           = {address_shift_reg[ADDR_W-mlrp_pkg::DIGIT_W-1:0], cls.hex_val};
        off_inc             = digit_offset_reg + DIG_W'(1);

        if (in_fire)
        begin
            if (opcode == mlrp_pkg::OP_START)
            begin
                digit_offset_next   = '0;
                address_shift_next  = '0;
                found_count_next    = '0;
                prev_was_o_next     = 1'b0;
                finished_next       = 1'b0;
                finish_error_next   = mlrp_pkg::ERR_NONE;
                match_seen_next     = 1'b0;
                choice_index_next   = '0;
                choice_address_next = '0;
            end
            else if (!finished_reg)
            begin
                if (cls.is_hex)
                begin
                    if (found_count_reg >= CNT_W'(MAX_DEVICES))
                    begin
                        finished_next     = 1'b1;
                        finish_error_next = mlrp_pkg::ERR_OVERFLOW;
                    end
                    else if (off_inc >= DIG_W'(ADDRESS_DIGITS))
                    begin
                        complete  = 1'b1;
                        completed = shift_val;
                        if (found_count_reg == '0)
                        begin
                            choice_index_next   = '0;
                            choice_address_next = shift_val;
                        end
                        if (!match_seen_reg && (shift_val == preferred_reg))
                        begin
                            match_seen_next     = 1'b1;
                            choice_index_next   = found_count_reg;
                            choice_address_next = shift_val;
                        end
                        found_count_next   = found_count_reg + CNT_W'(1);
                        digit_offset_next  = '0;
                        address_shift_next = '0;
                    end
                    else
                    begin
                        digit_offset_next  = off_inc;
                        address_shift_next = shift_val;
                    end
                end
                else if (!cls.is_filler)
                begin
                    finished_next     = 1'b1;
                    finish_error_next = mlrp_pkg::ERR_INVALID;
                end

                // An 'O' directly followed by 'K' closes the scan.
                if (!finished_next && prev_was_o_reg && cls.is_k)
                begin
                    finished_next = 1'b1;
                end
                prev_was_o_next = cls.is_o;
            end
        end
    end

    // Scan state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_offset_reg   <= '0;
            address_shift_reg  <= '0;
            found_count_reg    <= '0;
            prev_was_o_reg     <= 1'b0;
            finished_reg       <= 1'b1;
            finish_error_reg   <= mlrp_pkg::ERR_NONE;
            match_seen_reg     <= 1'b0;
            choice_index_reg   <= '0;
            choice_address_reg <= '0;
        end
        else
        begin
            digit_offset_reg   <= digit_offset_next;
            address_shift_reg  <= address_shift_next;
            found_count_reg    <= found_count_next;
            prev_was_o_reg     <= prev_was_o_next;
            finished_reg       <= finished_next;
            finish_error_reg   <= finish_error_next;
            match_seen_reg     <= match_seen_next;
            choice_index_reg   <= choice_index_next;
            choice_address_reg <= choice_address_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result word, loaded with the state after the accepted word.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            done_reg           <= finished_next;
            error_code_reg     <= finish_error_next;
            device_count_reg   <= 3'(found_count_next);
            complete_reg       <= complete;
            new_address_reg    <= completed;
            chosen_index_reg   <= 3'(choice_index_next);
            chosen_address_reg <= choice_address_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign done_res         = done_reg;
    assign error_code       = error_code_reg;
    assign device_count     = device_count_reg;
    assign address_complete = complete_reg;
    assign new_address      = new_address_reg;
    assign chosen_index     = chosen_index_reg;
    assign chosen_address   = chosen_address_reg;

    // Checks on the scan logic.
    `MLRP_ASSERT(a_count_bound, found_count_reg <= CNT_W'(MAX_DEVICES), "address count beyond maximum")
    `MLRP_ASSERT(a_complete_no_error, !(out_valid_reg && complete_reg) || (error_code_reg == mlrp_pkg::ERR_NONE), "address completed in a failed scan")
    `MLRP_ASSERT_NEXT(a_finished_sticky, in_fire && (opcode == mlrp_pkg::OP_CHAR) && finished_reg, finished_reg && !complete_reg, "finished scan reopened by a character")
    `MLRP_ASSERT(a_error_means_done, (finish_error_reg == mlrp_pkg::ERR_NONE) || finished_reg, "error recorded on an open scan")

endmodule
